>>> design/iowlt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iowlt_pkg
// Shared types, constants and helpers for the I/O window lookup block.
// ----------------------------------------------------------------------------
package iowlt_pkg;

    localparam int NUM_WINDOWS = 8;
    localparam int IDX_W       = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;
    localparam int CNT_W       = $clog2(NUM_WINDOWS + 1);
    localparam int OUT_IDX_W   = 3;

    localparam logic [1:0] OP_REG       = 2'd0;
    localparam logic [1:0] OP_FIND_IO   = 2'd1;
    localparam logic [1:0] OP_FIND_HOST = 2'd2;
    localparam logic [1:0] OP_XLATE     = 2'd3;

    localparam logic [31:0] PORT_MISS = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [7:0]  host;
        logic [31:0] io_base;
        logic [31:0] bus_base;
        logic [31:0] win_span;
    } entry_t;

    typedef struct packed {
        logic        io_hit;
        logic        host_hit;
        logic        xlate_hit;
        logic [31:0] port;
    } match_t;

    // Low bits of a window index as carried on the result port
    function automatic logic [OUT_IDX_W-1:0] out_idx(input logic [IDX_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[OUT_IDX_W-1:0];
    endfunction

endpackage
`default_nettype wire

>>> design/iowlt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iowlt_ram
// Generic simple dual-port RAM, one write and one read a cycle, registered read.
// ----------------------------------------------------------------------------
module iowlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> design/iowlt_match.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iowlt_match
// Compare unit shared by all lookups: tests one stored window per cycle.
// ----------------------------------------------------------------------------
module iowlt_match (
    input  wire logic [7:0]       host,
    input  wire logic [31:0]      addr,
    input  wire iowlt_pkg::entry_t entry,
    output iowlt_pkg::match_t     result
);
    import iowlt_pkg::*;

    logic [32:0] io_end;
    logic [31:0] bus_off;
    logic        host_eq;

    always_comb
    begin
        // 33-bit end so a window running past the top never wraps
        io_end  = {1'b0, entry.io_base} + {1'b0, entry.win_span};
        bus_off = addr - entry.bus_base;
        host_eq = (entry.host == host);

        result.io_hit    = ({1'b0, addr} < io_end) && (addr >= entry.io_base);
        result.host_hit  = host_eq;
        result.xlate_hit = host_eq && (addr >= entry.bus_base)
                           && (bus_off < entry.win_span);
        result.port      = entry.io_base + bus_off;
    end

endmodule
`default_nettype wire

>>> design/io_window_lookup_translate.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// io_window_lookup_translate
// Table of I/O windows with append, lookup by address or host, and
// bus-to-port translation.
// ----------------------------------------------------------------------------
// Usage:
//   One request enters on in_valid/in_ready with op, host_id, addr, io_base
//   and win_span; exactly one result leaves on out_valid/out_ready with
//   found, entry_index, port_addr and full_error.
//   An append (op 0) writes the window RAM in the accept cycle unless the
//   table is full, which sets full_error, and shows its result on the next
//   cycle. Lookups and translation read one stored window per cycle from the
//   RAM into the shared compare unit; find operations stop at the first hit.
//   An empty table answers in the next cycle.
//   The block holds one request at a time: in_ready is high only when no
//   request is in work and no result is waiting, so the next request is
//   taken at the earliest in the cycle after the result leaves.
//   A stalled receiver holds the result in the output registers until taken.
//   Reset empties the table at once (window count to zero); the RAM itself
//   is not cleared, since only written windows are ever read.
// ----------------------------------------------------------------------------
module io_window_lookup_translate (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  op,
    input  wire logic [7:0]  host_id,
    input  wire logic [31:0] addr,
    input  wire logic [31:0] io_base,
    input  wire logic [31:0] win_span,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             found,
    output logic [2:0]       entry_index,
    output logic [31:0]      port_addr,
    output logic             full_error
);
    import iowlt_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0]       op_reg, op_next;
    logic [7:0]       host_reg, host_next;
    logic [31:0]      addr_reg, addr_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0] last_reg, last_next;
    logic             issue_reg, issue_next;
    logic             cmp_valid_reg, cmp_valid_next;

    logic             found_reg, found_next;
    logic [2:0]       idx_reg, idx_next;
    logic [31:0]      port_reg, port_next;
    logic             err_reg, err_next;

    logic             accept;
    logic             table_full;
    logic [CNT_W-1:0] count_m1;
    logic             ram_we;
    logic             ram_re;
    entry_t           wr_entry;
    entry_t           rd_entry;
    match_t           match;
    logic             cur_hit;
    logic             cmp_last;

    assign accept     = in_valid && in_ready;
    assign table_full = (count_reg == CNT_W'(NUM_WINDOWS));
    assign count_m1   = count_reg - CNT_W'(1);
    assign ram_we     = accept && (op == OP_REG) && !table_full;
    assign ram_re     = (state_reg == ST_SCAN) && issue_reg;

    always_comb
    begin
        wr_entry.host     = host_id;
        wr_entry.io_base  = io_base;
        wr_entry.bus_base = addr;
        wr_entry.win_span = win_span;
    end

    iowlt_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (NUM_WINDOWS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (wr_entry),
        .re    (ram_re),
        .raddr (rd_idx_reg),
        .rdata (rd_entry)
    );

    iowlt_match u_match (
        .host   (host_reg),
        .addr   (addr_reg),
        .entry  (rd_entry),
        .result (match)
    );

    always_comb
    begin
        case (op_reg)
            OP_FIND_IO:   cur_hit = match.io_hit;
            OP_FIND_HOST: cur_hit = match.host_hit;
            default:      cur_hit = match.xlate_hit;
        endcase
        cmp_last = cmp_valid_reg && (cmp_idx_reg == last_reg);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_REG || count_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // First hit ends a find; translate runs to the last window
                if (cmp_last || (cmp_valid_reg && cur_hit && op_reg != OP_XLATE))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        count_next     = count_reg;
        op_next        = op_reg;
        host_next      = host_reg;
        addr_next      = addr_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        last_next      = last_reg;
        issue_next     = issue_reg;
        cmp_valid_next = 1'b0;
        found_next     = found_reg;
        idx_next       = idx_reg;
        port_next      = port_reg;
        err_next       = err_reg;

        in_ready  = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_DONE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next     = op;
                    host_next   = host_id;
                    addr_next   = addr;
                    rd_idx_next = '0;
                    last_next   = count_m1[IDX_W-1:0];
                    issue_next  = 1'b1;
                    found_next  = 1'b0;
                    idx_next    = '0;
                    port_next   = (op == OP_XLATE) ? PORT_MISS : 32'd0;
                    err_next    = 1'b0;
                    if (op == OP_REG)
                    begin
                        if (table_full)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            found_next = 1'b1;
                            idx_next   = out_idx(count_reg[IDX_W-1:0]);
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue_reg)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = rd_idx_reg;
                    if (rd_idx_reg == last_reg)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + IDX_W'(1);
                    end
                end
                if (cmp_valid_reg && cur_hit)
                begin
                    found_next = 1'b1;
                    idx_next   = out_idx(cmp_idx_reg);
                    if (op_reg == OP_XLATE)
                    begin
                        port_next = match.port;
                    end
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            issue_reg     <= 1'b0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        host_reg    <= host_next;
        addr_reg    <= addr_next;
        rd_idx_reg  <= rd_idx_next;
        cmp_idx_reg <= cmp_idx_next;
        last_reg    <= last_next;
        found_reg   <= found_next;
        idx_reg     <= idx_next;
        port_reg    <= port_next;
        err_reg     <= err_next;
    end

    assign found       = found_reg;
    assign entry_index = idx_reg;
    assign port_addr   = port_reg;
    assign full_error  = err_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(NUM_WINDOWS))
        else $error("window count exceeds table depth");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> count_reg != '0)
        else $error("scan started on an empty table");

    a_err_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && full_error |-> !found && op_reg == OP_REG)
        else $error("full error reported with a hit or on a lookup");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && op == OP_REG && !table_full |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("append did not grow the table");

    a_no_read_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("RAM read and write in the same cycle");

endmodule
`default_nettype wire
